// ===== rtl/xcrc_pkg.sv =====
// Package for the XMODEM-CRC receiver page writer.
// Holds frame constants, payload and command types, and the byte-wise CRC function.
// No dependencies; every module of the block imports it.
package xcrc_pkg;

    localparam int PAYLOAD_BYTES  = 128;
    localparam int ADDR_BITS      = 21;
    localparam int WORD_ADDR_BITS = ADDR_BITS - 1;
    localparam int WORDS          = PAYLOAD_BYTES / 2;
    localparam int PIDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int WIDX_W         = $clog2(WORDS);
    localparam int LAST_IDX       = WORDS - 1;

    // Frame layout: SOH, block, complement, payload, CRC high, CRC low
    localparam int POS_PAYLOAD = 3;
    localparam int POS_CRC_HI  = POS_PAYLOAD + PAYLOAD_BYTES;
    localparam int POS_CRC_LO  = POS_CRC_HI + 1;
    localparam int POS_W       = $clog2(POS_CRC_LO + 1);

    localparam logic [7:0]  EOT_BYTE  = 8'h04;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    // Command queue depth between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic                      word_valid;
        logic [WORD_ADDR_BITS-1:0] word_address;
        logic [15:0]               word_data;
        logic [1:0]                reply;
        logic                      transfer_done;
        logic                      last;
    } result_t;

    typedef enum logic [1:0] {
        CMD_EOT  = 2'd0,
        CMD_NAK  = 2'd1,
        CMD_GOOD = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic [WORD_ADDR_BITS-1:0] word_addr;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [WIDX_W-1:0] addr;
        logic [15:0]       data;
    } mem_wr_t;

    // Fold one byte into CRC-16/XMODEM, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

// ===== rtl/xcrc_front.sv =====
// Front end of the page writer: tracks frame position, runs the CRC, writes payload words.
// Emits one command per EOT or finished packet into the command queue.
// Depends on xcrc_pkg.
module xcrc_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [xcrc_pkg::ADDR_BITS-1:0]       cfg_wr_data,
    input  logic                                 push,
    output logic                                 full,
    input  xcrc_pkg::in_item_t                   in_item,
    output logic                                 cmd_push,
    output xcrc_pkg::cmd_t                       cmd_data,
    input  logic                                 cmd_full,
    output xcrc_pkg::mem_wr_t                    mem_wr,
    input  logic                                 drain_done
);
    import xcrc_pkg::*;

    logic [ADDR_BITS-1:0] start_addr_reg, start_addr_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 active_reg, active_next;
    logic                 drain_pending_reg, drain_pending_next;
    logic [15:0]          crc_reg, crc_next;
    logic [7:0]           crc_hi_reg, crc_hi_next;
    logic [7:0]           hold_reg, hold_next;
    logic [POS_W-1:0]     offset;
    logic                 accept;

    // Stall while the queue is full or a good packet is still being read out
    assign full   = cmd_full || drain_pending_reg;
    assign accept = push && !full;
    assign offset = pos_reg - POS_W'(POS_PAYLOAD);

    // Classify the byte and compute next state
    always_comb
    begin
        start_addr_next    = start_addr_reg;
        addr_next          = addr_reg;
        pos_next           = pos_reg;
        active_next        = active_reg;
        drain_pending_next = drain_pending_reg;
        crc_next           = crc_reg;
        crc_hi_next        = crc_hi_reg;
        hold_next          = hold_reg;
        cmd_push           = 1'b0;
        cmd_data.kind      = CMD_NAK;
        cmd_data.word_addr = addr_reg[ADDR_BITS-1:1];
        mem_wr.en          = 1'b0;
        mem_wr.addr        = offset[PIDX_W-1:1];
        mem_wr.data        = {hold_reg, in_item.rx_byte};

        if (cfg_wr_en)
            start_addr_next = cfg_wr_data;

        if (drain_done)
            drain_pending_next = 1'b0;

        if (accept)
        begin
            if (in_item.cmd)
            begin
                pos_next    = '0;
                addr_next   = start_addr_reg;
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                if (pos_reg == '0)
                begin
                    pos_next = POS_W'(1);
                    crc_next = '0;
                    if (in_item.rx_byte == EOT_BYTE)
                    begin
                        active_next   = 1'b0;
                        cmd_push      = 1'b1;
                        cmd_data.kind = CMD_EOT;
                    end
                end
                else if (pos_reg == POS_W'(POS_CRC_HI))
                begin
                    crc_hi_next = in_item.rx_byte;
                    pos_next    = pos_reg + POS_W'(1);
                end
                else if (pos_reg == POS_W'(POS_CRC_LO))
                begin
                    pos_next = '0;
                    cmd_push = 1'b1;
                    if (crc_reg == {crc_hi_reg, in_item.rx_byte})
                    begin
                        cmd_data.kind      = CMD_GOOD;
                        addr_next          = addr_reg + ADDR_BITS'(PAYLOAD_BYTES);
                        drain_pending_next = 1'b1;
                    end
                end
                else
                begin
                    if (pos_reg >= POS_W'(POS_PAYLOAD))
                    begin
                        crc_next = crc_byte(crc_reg, in_item.rx_byte);
                        if (!offset[0])
                            hold_next = in_item.rx_byte;
                        else
                            mem_wr.en = 1'b1;
                    end
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    // Control and address registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_addr_reg    <= '0;
            addr_reg          <= '0;
            pos_reg           <= '0;
            active_reg        <= 1'b0;
            drain_pending_reg <= 1'b0;
            crc_reg           <= '0;
            crc_hi_reg        <= '0;
        end
        else
        begin
            start_addr_reg    <= start_addr_next;
            addr_reg          <= addr_next;
            pos_reg           <= pos_next;
            active_reg        <= active_next;
            drain_pending_reg <= drain_pending_next;
            crc_reg           <= crc_next;
            crc_hi_reg        <= crc_hi_next;
        end
    end

    // Hold the first byte of each payload pair
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // Never touch payload words while a good packet is still being read
    a_no_write_during_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> !drain_pending_reg)
        else $error("payload write while drain pending");

    // Never push a command into a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command push into full queue");

    // A good packet always leaves a drain pending
    a_good_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd_data.kind == CMD_GOOD) |=> drain_pending_reg)
        else $error("good packet without drain pending");

endmodule

// ===== rtl/xcrc_cmd_fifo.sv =====
// Short command queue between the front and back ends of the page writer.
// Registered storage with read and write pointers and an occupancy count.
// Depends on xcrc_pkg.
module xcrc_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  xcrc_pkg::cmd_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output xcrc_pkg::cmd_t rd_data,
    output logic           q_empty
);
    import xcrc_pkg::*;

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_PTR_W:0]   count_reg, count_next;

    assign q_full  = (count_reg == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = wr_ptr_reg + CMDQ_PTR_W'(1);
        if (rd_en)
            rd_ptr_next = rd_ptr_reg + CMDQ_PTR_W'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + (CMDQ_PTR_W + 1)'(1);
        else if (!wr_en && rd_en)
            count_next = count_reg - (CMDQ_PTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/xcrc_back.sv =====
// Back end of the page writer: holds the payload word memory and turns commands into results.
// Reads each word of a good packet in a read step, then loads it in a load step that waits for a free output register.
// Depends on xcrc_pkg.
module xcrc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  xcrc_pkg::cmd_t    cmd_data,
    output logic              cmd_pop,
    input  xcrc_pkg::mem_wr_t mem_wr,
    output logic              drain_done,
    input  logic              pop,
    output logic              empty,
    output xcrc_pkg::result_t result
);
    import xcrc_pkg::*;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_RD   = 3'b010,
        BK_LD   = 3'b100
    } bk_state_t;

    bk_state_t                 state_reg, state_next;
    logic [WIDX_W-1:0]         idx_reg, idx_next;
    logic [WORD_ADDR_BITS-1:0] base_reg, base_next;
    logic                      out_valid_reg, out_valid_next;
    result_t                   out_reg, out_next;
    logic [15:0]               mem [WORDS];
    logic [15:0]               rd_data_reg;
    logic                      rd_en;
    logic                      can_load;
    logic                      load_out;
    logic                      idx_last;

    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign can_load = !out_valid_reg || pop;
    assign idx_last = (idx_reg == WIDX_W'(LAST_IDX));

    // Sequence commands into results
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        drain_done     = 1'b0;
        load_out       = 1'b0;

        if (pop && out_valid_reg)
            out_valid_next = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (cmd_data.kind == CMD_GOOD)
                    begin
                        cmd_pop    = 1'b1;
                        base_next  = cmd_data.word_addr;
                        idx_next   = '0;
                        state_next = BK_RD;
                    end
                    else if (can_load)
                    begin
                        cmd_pop                = 1'b1;
                        load_out               = 1'b1;
                        out_next.word_valid    = 1'b0;
                        out_next.word_address  = '0;
                        out_next.word_data     = '0;
                        out_next.last          = 1'b1;
                        out_next.transfer_done = (cmd_data.kind == CMD_EOT);
                        out_next.reply         = (cmd_data.kind == CMD_EOT) ? REPLY_ACK
                                                                            : REPLY_NAK;
                    end
                end
            end
            BK_RD:
            begin
                rd_en      = 1'b1;
                drain_done = idx_last;
                state_next = BK_LD;
            end
            BK_LD:
            begin
                if (can_load)
                begin
                    load_out               = 1'b1;
                    out_next.word_valid    = 1'b1;
                    out_next.word_address  = base_reg + WORD_ADDR_BITS'(idx_reg);
                    out_next.word_data     = rd_data_reg;
                    out_next.reply         = idx_last ? REPLY_ACK : REPLY_NONE;
                    out_next.transfer_done = 1'b0;
                    out_next.last          = idx_last;
                    if (idx_last)
                        state_next = BK_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + WIDX_W'(1);
                        state_next = BK_RD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Payload word memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
            mem[mem_wr.addr] <= mem_wr.data;
        if (rd_en)
            rd_data_reg <= mem[idx_reg];
    end

    // Load only into a free or departing output register
    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || pop))
        else $error("result overwritten before it was taken");

    // A load step always follows a memory read step
    a_ld_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LD) |-> ($past(state_reg) == BK_RD || $past(state_reg) == BK_LD))
        else $error("load step without memory read");

    // Memory read data stays put while the load step waits
    a_rd_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_LD && $past(state_reg) == BK_LD) |-> $stable(rd_data_reg))
        else $error("read data changed during load wait");

endmodule

// ===== rtl/xmodem_crc_receiver_page_writer.sv =====
// XMODEM-CRC receiver page writer: one link byte per transaction, at most one per cycle.
// Input stalls (full) from the good packet's CRC byte until its last word is read from the
// payload memory by its single read port, and also while the command queue is full.
// EOT/NAK results pass the command queue and output register; words also pass the read step.
// Reset clears control state, address registers and queues; the payload memory is not cleared.
module xmodem_crc_receiver_page_writer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [xcrc_pkg::ADDR_BITS-1:0] cfg_wr_data,
    input  logic                           push,
    output logic                           full,
    input  xcrc_pkg::in_item_t             in_item,
    input  logic                           pop,
    output logic                           empty,
    output xcrc_pkg::result_t              result
);
    import xcrc_pkg::*;

    logic    cmd_push;
    cmd_t    cmd_wr_data;
    logic    cmd_full;
    logic    cmd_pop;
    cmd_t    cmd_rd_data;
    logic    cmd_empty;
    mem_wr_t mem_wr;
    logic    drain_done;

    // Classify bytes, check CRC, write payload
    xcrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_wr_data),
        .cmd_full    (cmd_full),
        .mem_wr      (mem_wr),
        .drain_done  (drain_done)
    );

    // Decouple front and back
    xcrc_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wr_data),
        .q_full  (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd_data),
        .q_empty (cmd_empty)
    );

    // Drain commands into results
    xcrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_data   (cmd_rd_data),
        .cmd_pop    (cmd_pop),
        .mem_wr     (mem_wr),
        .drain_done (drain_done),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

// ===== verif/tb_xmodem_crc_receiver_page_writer.sv =====
// Self-checking testbench for xmodem_crc_receiver_page_writer: link bytes in, flash
// word writes and ACK/NAK replies out, checked in order against an in-bench predictor.
// Depends on xcrc_pkg and the xmodem_crc_receiver_page_writer RTL only.
module tb_xmodem_crc_receiver_page_writer;
    import xcrc_pkg::*;

    localparam logic       LINK_BYTE   = 1'b0;
    localparam logic       LINK_START  = 1'b1;
    localparam logic [7:0] SOH_BYTE    = 8'h01;
    localparam int         FRAME_LEN   = POS_CRC_LO + 1;
    localparam int         HOLD_CYCLES = 600;
    localparam int         STALL_LIMIT = 4000;
    localparam int         FEED_TARGET = 380;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [ADDR_BITS-1:0] cfg_wr_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    in_item_t             in_item = '0;
    logic                 pop = 1'b0;
    logic                 empty;
    result_t              result;

    xmodem_crc_receiver_page_writer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

    // Link bytes waiting to be offered, and flash operations owed by the block
    in_item_t link_q[$];
    result_t  flash_ops_q[$];

    int  links_queued   = 0;
    int  links_taken    = 0;
    int  feed_count     = 0;
    int  mismatch_count = 0;
    int  idle_pct       = 0;
    int  stall_pct      = 0;
    bit  hold_req       = 1'b0;
    bit  hold_done      = 1'b0;
    int  hold_left      = 0;
    bit  in_fire        = 1'b0;
    bit  out_fire       = 1'b0;
    int  quiet_cycles   = 0;

    // Receiver state as the predictor sees it
    logic [ADDR_BITS-1:0] cfg_start   = '0;
    logic [7:0]           frame_pos   = '0;
    logic [7:0]           store [PAYLOAD_BYTES];
    int                   stored_cnt  = 0;
    logic [7:0]           crc_hi_seen = '0;
    logic [ADDR_BITS-1:0] flash_addr  = '0;
    bit                   xfer_active = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    // CRC-16/XMODEM, one bit at a time, MSB first
    function automatic logic [15:0] xmodem_fold(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    // Advance the receiver by one link byte and queue what it owes
    function automatic void absorb_link_byte(input in_item_t it);
        result_t     r;
        logic [15:0] crc;
        if (it.cmd == LINK_START) begin
            frame_pos   = '0;
            stored_cnt  = 0;
            flash_addr  = cfg_start;
            xfer_active = 1'b1;
            return;
        end
        if (!xfer_active)
            return;
        if (frame_pos == 0) begin
            stored_cnt = 0;
            frame_pos  = 8'd1;
            if (it.rx_byte == EOT_BYTE) begin
                xfer_active     = 1'b0;
                r               = '0;
                r.reply         = REPLY_ACK;
                r.transfer_done = 1'b1;
                r.last          = 1'b1;
                flash_ops_q.push_back(r);
            end
            return;
        end
        if (frame_pos == POS_CRC_HI) begin
            crc_hi_seen = it.rx_byte;
            frame_pos++;
            return;
        end
        if (frame_pos >= POS_CRC_LO) begin
            frame_pos = '0;
            crc       = '0;
            for (int i = 0; i < PAYLOAD_BYTES; i++)
                crc = xmodem_fold(crc, store[i]);
            if (crc == {crc_hi_seen, it.rx_byte}) begin
                for (int w = 0; w < WORDS; w++) begin
                    r              = '0;
                    r.word_valid   = 1'b1;
                    r.word_address = flash_addr[ADDR_BITS-1:1];
                    r.word_data    = {store[2*w], store[2*w+1]};
                    r.reply        = (w == LAST_IDX) ? REPLY_ACK : REPLY_NONE;
                    r.last         = (w == LAST_IDX);
                    flash_ops_q.push_back(r);
                    flash_addr     = flash_addr + ADDR_BITS'(2);
                end
            end
            else begin
                r       = '0;
                r.reply = REPLY_NAK;
                r.last  = 1'b1;
                flash_ops_q.push_back(r);
            end
            return;
        end
        if (frame_pos >= POS_PAYLOAD && stored_cnt < PAYLOAD_BYTES) begin
            store[stored_cnt] = it.rx_byte;
            stored_cnt++;
        end
        frame_pos++;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatch_count++;
    endtask

    // Sample both handshakes, predict, check, and watch for a hang
    always @(posedge clk) begin
        result_t want;
        in_fire  = rst_n && push && !full;
        out_fire = rst_n && pop && !empty;
        if (in_fire) begin
            absorb_link_byte(in_item);
            links_taken++;
        end
        if (out_fire) begin
            if (flash_ops_q.size() == 0)
                flag_mismatch("result with nothing owed", 32'(result.word_data), 32'h0);
            else begin
                want = flash_ops_q.pop_front();
                if (result.word_valid != want.word_valid)
                    flag_mismatch("word_valid", 32'(result.word_valid),
                                  32'(want.word_valid));
                if (result.word_address != want.word_address)
                    flag_mismatch("word_address", 32'(result.word_address),
                                  32'(want.word_address));
                if (result.word_data != want.word_data)
                    flag_mismatch("word_data", 32'(result.word_data), 32'(want.word_data));
                if (result.reply != want.reply)
                    flag_mismatch("reply", 32'(result.reply), 32'(want.reply));
                if (result.transfer_done != want.transfer_done)
                    flag_mismatch("transfer_done", 32'(result.transfer_done),
                                  32'(want.transfer_done));
                if (result.last != want.last)
                    flag_mismatch("last", 32'(result.last), 32'(want.last));
            end
        end
        if (in_fire || out_fire || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Sender: hold an offered byte until taken, else offer the next or idle
    always @(negedge clk) begin
        if (!rst_n)
            push <= 1'b0;
        else if (push && !in_fire) begin
            // hold the current transaction
        end
        else if (link_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            push    <= 1'b1;
            in_item <= link_q.pop_front();
        end
        else
            push <= 1'b0;
    end

    // Receiver: one long hold-off on request, otherwise random stalls
    always @(negedge clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end
        else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send(input logic c, input logic [7:0] b, input bit counted);
        in_item_t it;
        it.cmd     = c;
        it.rx_byte = b;
        link_q.push_back(it);
        links_queued++;
        if (counted)
            feed_count++;
    endtask

    // Queue one frame; cut > 0 aborts it with a start after that many bytes
    task automatic send_packet(input bit good, input int cut);
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] crc;
        int          fill;
        int          n;
        fill = $urandom_range(9);
        crc  = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            frame[POS_PAYLOAD+i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF
                                                     : 8'($urandom_range(255));
            crc = xmodem_fold(crc, frame[POS_PAYLOAD+i]);
        end
        if (!good)
            crc = crc ^ 16'($urandom_range(1, 65535));
        // any non-EOT byte at frame start is taken as SOH
        frame[0] = SOH_BYTE;
        if ($urandom_range(3) == 0) begin
            frame[0] = 8'($urandom_range(255));
            if (frame[0] == EOT_BYTE)
                frame[0] = SOH_BYTE;
        end
        frame[1]          = 8'($urandom_range(255));
        frame[2]          = ~frame[1];
        frame[POS_CRC_HI] = crc[15:8];
        frame[POS_CRC_LO] = crc[7:0];
        n = (cut > 0) ? cut : FRAME_LEN;
        for (int i = 0; i < n; i++)
            send(LINK_BYTE, frame[i], 1'b1);
        if (cut > 0)
            send(LINK_START, 8'($urandom_range(255)), 1'b1);
    endtask

    // Half well-formed random frames; others bad-CRC, cut short, EOT with junk, or a restart
    task automatic random_sequence();
        int pick;
        int junk;
        pick = $urandom_range(99);
        if (pick < 50)
            send_packet(1'b1, 0);
        else if (pick < 62)
            send_packet(1'b0, 0);
        else if (pick < 74)
            send_packet(1'($urandom_range(1)), $urandom_range(1, FRAME_LEN - 1));
        else if (pick < 88) begin
            send(LINK_BYTE, EOT_BYTE, 1'b1);
            junk = $urandom_range(3);
            for (int i = 0; i < junk; i++)
                send(LINK_BYTE, 8'($urandom_range(255)), 1'b0);
            send(LINK_START, 8'($urandom_range(255)), 1'b1);
        end
        else
            send(LINK_START, 8'($urandom_range(255)), 1'b1);
    endtask

    task automatic wait_drained();
        while (links_taken != links_queued || flash_ops_q.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_start_address(input logic [ADDR_BITS-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cfg_start    = v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [ADDR_BITS-1:0] start_pick [4];
        start_pick[0] = '0;
        start_pick[1] = '1;
        start_pick[2] = ADDR_BITS'($urandom_range(0, 2097151)) | ADDR_BITS'(1);
        start_pick[3] = ADDR_BITS'($urandom_range(0, 2097151));

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: bytes while idle, EOT at frame start, restart while active
        send(LINK_BYTE, 8'h00, 1'b0);
        send(LINK_BYTE, 8'hFF, 1'b0);
        send(LINK_BYTE, EOT_BYTE, 1'b0);
        send(LINK_START, 8'h00, 1'b1);
        send(LINK_BYTE, EOT_BYTE, 1'b1);
        send(LINK_START, 8'hFF, 1'b1);
        send(LINK_BYTE, SOH_BYTE, 1'b1);
        send(LINK_BYTE, 8'h7E, 1'b1);
        send(LINK_START, 8'h55, 1'b1);
        send(LINK_BYTE, EOT_BYTE, 1'b1);

        // Phases: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            idle_pct  = (ph == 1) ? 77 : (ph == 3) ? 19 : 0;
            stall_pct = (ph == 2) ? 77 : (ph == 3) ? 19 : 0;
            write_start_address(start_pick[ph]);
            send(LINK_START, 8'($urandom_range(255)), 1'b1);
            if (ph == 0) begin
                // hold off the receiver while a good frame and more bytes keep coming
                hold_req = 1'b1;
                send_packet(1'b1, 0);
                send(LINK_START, 8'($urandom_range(255)), 1'b1);
                send(LINK_BYTE, EOT_BYTE, 1'b1);
            end
            while (feed_count < FEED_TARGET * (ph + 1) / 4)
                random_sequence();
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (flash_ops_q.size() != 0)
            flag_mismatch("results never delivered", flash_ops_q.size(), 32'h0);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/xcrc_pkg.sv
rtl/xcrc_front.sv
rtl/xcrc_cmd_fifo.sv
rtl/xcrc_back.sv
rtl/xmodem_crc_receiver_page_writer.sv
verif/tb_xmodem_crc_receiver_page_writer.sv
